>>> sv/cpr_pkg.sv
`default_nettype none

package cpr_pkg;

    // Payload field widths
    localparam int PROC_W   = 4;
    localparam int ADDR_W   = 17;
    localparam int STATUS_W = 2;
    localparam int PAGE_W   = 7;
    localparam int FRAME_W  = 4;

    // Configuration register widths
    localparam int PW_W      = 11;
    localparam int PP_W      = 7;
    localparam int FC_W      = 5;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_WORDS        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_PER_PROCESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT       = 2'd2;

    // Configuration reset values
    localparam logic [PW_W-1:0] PW_RESET = 11'd256;
    localparam logic [PP_W-1:0] PP_RESET = 7'd8;
    localparam logic [FC_W-1:0] FC_RESET = 5'd16;

    // Address limit is page_words * pages_per_process
    localparam int LIMIT_W = PW_W + PP_W;

    // One quotient bit per divider step
    localparam int DIV_STEPS = ADDR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT  = 2'd0,
        ST_FILL = 2'd1,
        ST_REPL = 2'd2,
        ST_BAD  = 2'd3
    } status_t;

endpackage

`default_nettype wire

>>> sv/cpr_req_if.sv
`default_nettype none

interface cpr_req_if;
    import cpr_pkg::*;

    logic              valid;
    logic              ready;
    logic [PROC_W-1:0] process;
    logic [ADDR_W-1:0] word_address;

    modport source (output valid, output process, output word_address, input ready);
    modport sink   (input valid, input process, input word_address, output ready);
endinterface

`default_nettype wire

>>> sv/cpr_rsp_if.sv
`default_nettype none

interface cpr_rsp_if;
    import cpr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page;
    logic [FRAME_W-1:0]  frame;
    logic [PROC_W-1:0]   victim_process;
    logic [PAGE_W-1:0]   victim_page;
    logic [FRAME_W-1:0]  hand;

    modport source (output valid, output status, output page, output frame,
                    output victim_process, output victim_page, output hand,
                    input ready);
    modport sink   (input valid, input status, input page, input frame,
                    input victim_process, input victim_page, input hand,
                    output ready);
endinterface

`default_nettype wire

>>> sv/clock_page_replacement.sv
// Clock (second-chance) page replacement unit.
// req carries one memory access word (process, one-based word_address); rsp
// returns one result word per access: status, page, frame, victim and hand.
// cfg_we/cfg_index/cfg_data write page_words, pages_per_process and
// frame_count; write them only while no access is in flight.
// One access at a time. From acceptance to rsp.valid the steps are:
//   bad request: check, then finish
//   otherwise:   check, restoring divider (one quotient bit a cycle),
//                frame table search (one frame read a cycle),
//                clock sweep (one frame a cycle) and victim read if no frame
//                is free and the page is not found, then finish.
// req.ready is high only while the sequencer is idle, from the cycle after a
// result is loaded, so a new access is taken only once the last result is loaded.
// A finished result waits in an output register; the next access may be taken
// meanwhile, and its result is held internally until rsp.ready frees the
// output register.
// Reset clears the reference bits, the fill count, the clock hand and the
// configuration (256 words/page, 8 pages, 16 frames). Frame table contents
// are not cleared; only filled frames are ever read.
`default_nettype none

module clock_page_replacement #(
    parameter int MAX_FRAMES    = 16,
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_PAGES     = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [cpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cpr_pkg::CFG_DATA_W-1:0] cfg_data,
    cpr_req_if.sink                        req,
    cpr_rsp_if.source                      rsp
);
    import cpr_pkg::*;

    localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FCNT_W = $clog2(MAX_FRAMES + 1);
    localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES + 1) : 1;
    localparam int MEM_W  = PROC_W + PG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SEARCH,
        S_SWEEP,
        S_VREAD,
        S_FINISH
    } state_t;

    state_t state_reg;

    // Configuration
    logic [PW_W-1:0] pw_reg;
    logic [PP_W-1:0] pp_reg;
    logic [FC_W-1:0] fc_reg;

    // Replacement state
    logic [MEM_W-1:0]      frame_mem [MAX_FRAMES];
    logic [MEM_W-1:0]      rd_word_reg;
    logic [MAX_FRAMES-1:0] refbit_reg;
    logic [FCNT_W-1:0]     frames_used_reg;
    logic [FIDX_W-1:0]     hand_reg;

    // Access being worked on
    logic [PROC_W-1:0]  proc_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [PG_W-1:0]    page_reg;
    logic [PW_W-1:0]    rem_reg;
    logic [ADDR_W-1:0]  quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [FCNT_W-1:0]  scan_reg;
    logic               cmp_valid_reg;
    logic [FIDX_W-1:0]  cmp_idx_reg;

    // Pending result
    status_t            res_status_reg;
    logic [PAGE_W-1:0]  res_page_reg;
    logic [FIDX_W-1:0]  res_frame_reg;
    logic [PROC_W-1:0]  res_vproc_reg;
    logic [PAGE_W-1:0]  res_vpage_reg;

    // Output register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [PAGE_W-1:0]   out_page_reg;
    logic [FRAME_W-1:0]  out_frame_reg;
    logic [PROC_W-1:0]   out_vproc_reg;
    logic [PAGE_W-1:0]   out_vpage_reg;
    logic [FRAME_W-1:0]  out_hand_reg;

    // Effective configuration
    logic [PW_W-1:0]   pw_eff;
    logic [PP_W-1:0]   pp_eff;
    logic [FCNT_W-1:0] nf_eff;
    logic [FCNT_W-1:0] used_eff;
    logic [FCNT_W-1:0] hand_wide;
    logic [FIDX_W-1:0] hand_adv;
    logic              free_left;
    logic              scan_more;
    logic [MEM_W-1:0]  key;
    logic              hit_now;
    logic              bad_req;

    // Divider step
    logic [PW_W:0]     trial;
    logic              qbit;
    logic [PW_W-1:0]   rem_next;
    logic [ADDR_W-1:0] quo_next;

    // Frame table port
    logic [FIDX_W-1:0] rd_addr;
    logic              mem_we;
    logic [FIDX_W-1:0] mem_waddr;

    always_comb
    begin
        pw_eff = (pw_reg == '0) ? PW_W'(1) : pw_reg;
        pp_eff = (pp_reg == '0) ? PP_W'(1) : pp_reg;
        if (int'(pp_eff) > MAX_PAGES)
        begin
            pp_eff = PP_W'(MAX_PAGES);
        end
        if (fc_reg == '0)
        begin
            nf_eff = FCNT_W'(1);
        end
        else if (int'(fc_reg) > MAX_FRAMES)
        begin
            nf_eff = FCNT_W'(MAX_FRAMES);
        end
        else
        begin
            nf_eff = FCNT_W'(fc_reg);
        end
        used_eff  = (frames_used_reg < nf_eff) ? frames_used_reg : nf_eff;
        free_left = frames_used_reg < nf_eff;
        scan_more = scan_reg < used_eff;
        hand_wide = FCNT_W'(hand_reg) + FCNT_W'(1);
        hand_adv  = (hand_wide == nf_eff) ? '0 : FIDX_W'(hand_wide);
        key       = {proc_reg, page_reg};
        hit_now   = cmp_valid_reg && (rd_word_reg == key);
        bad_req   = (addr_reg == '0) || ({1'b0, addr_reg} > limit_reg)
                    || (int'(proc_reg) >= MAX_PROCESSES);

        trial    = {rem_reg, quo_reg[ADDR_W-1]};
        qbit     = trial >= {1'b0, pw_eff};
        rem_next = qbit ? PW_W'(trial - {1'b0, pw_eff}) : PW_W'(trial);
        quo_next = {quo_reg[ADDR_W-2:0], qbit};
    end

    always_comb
    begin
        rd_addr   = (state_reg == S_SEARCH) ? scan_reg[FIDX_W-1:0] : hand_reg;
        mem_we    = 1'b0;
        mem_waddr = hand_reg;
        if (state_reg == S_SEARCH && !hit_now && !scan_more && free_left)
        begin
            mem_we    = 1'b1;
            mem_waddr = frames_used_reg[FIDX_W-1:0];
        end
        else if (state_reg == S_VREAD)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= key;
        end
        rd_word_reg <= frame_mem[rd_addr];
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.page           = out_page_reg;
    assign rsp.frame          = out_frame_reg;
    assign rsp.victim_process = out_vproc_reg;
    assign rsp.victim_page    = out_vpage_reg;
    assign rsp.hand           = out_hand_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pw_reg          <= PW_RESET;
            pp_reg          <= PP_RESET;
            fc_reg          <= FC_RESET;
            refbit_reg      <= '0;
            frames_used_reg <= '0;
            hand_reg        <= '0;
            cmp_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PAGE_WORDS:        pw_reg <= cfg_data[PW_W-1:0];
                    CFG_PAGES_PER_PROCESS: pp_reg <= cfg_data[PP_W-1:0];
                    CFG_FRAME_COUNT:       fc_reg <= cfg_data[FC_W-1:0];
                    default:               ;
                endcase
            end

            if (out_valid_reg && rsp.ready && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        proc_reg  <= req.process;
                        addr_reg  <= req.word_address;
                        limit_reg <= LIMIT_W'({{PP_W{1'b0}}, pw_eff}
                                              * {{PW_W{1'b0}}, pp_eff});
                        state_reg <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    if (bad_req)
                    begin
                        res_status_reg <= ST_BAD;
                        res_page_reg   <= '0;
                        res_frame_reg  <= '0;
                        res_vproc_reg  <= '0;
                        res_vpage_reg  <= '0;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        // wrap a hand left beyond a shrunk frame count
                        if (FCNT_W'(hand_reg) >= nf_eff)
                        begin
                            hand_reg <= '0;
                        end
                        rem_reg     <= '0;
                        quo_reg     <= addr_reg - ADDR_W'(1);
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    rem_reg     <= rem_next;
                    quo_reg     <= quo_next;
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    begin
                        page_reg      <= PG_W'(quo_next) + PG_W'(1);
                        res_page_reg  <= PAGE_W'(PG_W'(quo_next) + PG_W'(1));
                        scan_reg      <= '0;
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= S_SEARCH;
                    end
                end

                S_SEARCH:
                begin
                    if (hit_now)
                    begin
                        refbit_reg[cmp_idx_reg] <= 1'b1;
                        res_status_reg <= ST_HIT;
                        res_frame_reg  <= cmp_idx_reg;
                        res_vproc_reg  <= '0;
                        res_vpage_reg  <= '0;
                        cmp_valid_reg  <= 1'b0;
                        state_reg      <= S_FINISH;
                    end
                    else if (scan_more)
                    begin
                        // read issued now, compared next cycle
                        cmp_valid_reg <= 1'b1;
                        cmp_idx_reg   <= scan_reg[FIDX_W-1:0];
                        scan_reg      <= scan_reg + FCNT_W'(1);
                    end
                    else if (free_left)
                    begin
                        refbit_reg[frames_used_reg[FIDX_W-1:0]] <= 1'b1;
                        frames_used_reg <= frames_used_reg + FCNT_W'(1);
                        hand_reg        <= hand_adv;
                        res_status_reg  <= ST_FILL;
                        res_frame_reg   <= frames_used_reg[FIDX_W-1:0];
                        res_vproc_reg   <= '0;
                        res_vpage_reg   <= '0;
                        cmp_valid_reg   <= 1'b0;
                        state_reg       <= S_FINISH;
                    end
                    else
                    begin
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= S_SWEEP;
                    end
                end

                S_SWEEP:
                begin
                    // second chance: clear and advance past referenced frames
                    if (refbit_reg[hand_reg])
                    begin
                        refbit_reg[hand_reg] <= 1'b0;
                        hand_reg             <= hand_adv;
                    end
                    else
                    begin
                        state_reg <= S_VREAD;
                    end
                end

                S_VREAD:
                begin
                    refbit_reg[hand_reg] <= 1'b1;
                    res_status_reg <= ST_REPL;
                    res_frame_reg  <= hand_reg;
                    res_vproc_reg  <= rd_word_reg[MEM_W-1 -: PROC_W];
                    res_vpage_reg  <= PAGE_W'(rd_word_reg[PG_W-1:0]);
                    hand_reg       <= hand_adv;
                    state_reg      <= S_FINISH;
                end

                S_FINISH:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_page_reg   <= res_page_reg;
                        out_frame_reg  <= FRAME_W'(res_frame_reg);
                        out_vproc_reg  <= res_vproc_reg;
                        out_vpage_reg  <= res_vpage_reg;
                        out_hand_reg   <= FRAME_W'(hand_reg);
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_accept_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == S_CHECK)
        else $error("accepted word did not start the check step");

    a_output_loads_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result word appeared outside the finish step");

    a_result_frame_referenced: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && res_status_reg != ST_BAD |-> refbit_reg[res_frame_reg])
        else $error("frame holding the page has a clear reference bit");

    a_divider_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_cnt_reg < DIV_CNT_W'(DIV_STEPS))
        else $error("divider ran past its step count");
`endif

endmodule

`default_nettype wire
